>>> sv/mcsp_pkg.sv
// mcsp_pkg: request codes, payload structs and channel control bundle
// for the multi-channel slow pwm unit; no dependencies
package mcsp_pkg;

	localparam int DUTY_W  = 11;
	localparam int COUNT_W = 16;
	localparam int PINS_W  = 3;

	localparam logic [DUTY_W-1:0] DUTY_FULL = 11'd1024;
	localparam logic [DUTY_W-1:0] DUTY_SAT  = 11'd1023;

	// configuration register indexes
	localparam logic CFG_PERIOD      = 1'b0;
	localparam logic CFG_ACTIVE_HIGH = 1'b1;

	localparam logic [COUNT_W-1:0] PERIOD_RESET = 16'd100;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_SET    = 2'd1,
		REQ_OFF    = 2'd2,
		REQ_ENABLE = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t         req_type;
		logic [1:0]        channel;
		logic [DUTY_W-1:0] duty_value;
	} req_item_t;

	typedef struct packed {
		logic [PINS_W-1:0] pin_levels;
		logic [PINS_W-1:0] channels_on;
		logic              output_enabled;
		logic [DUTY_W-1:0] duty_readback;
		logic              status;
	} res_item_t;

	// per-channel update strobes for one request
	typedef struct packed {
		logic load;      // set duty addressed to this channel
		logic clear;     // force all off
		logic tick_run;  // tick while enabled
		logic tick_off;  // tick while disabled
	} chan_ctrl_t;

endpackage

>>> sv/mcsp_chan.sv
// mcsp_chan: duty register and on flag of one pwm channel with its window compare
// depends on mcsp_pkg
module mcsp_chan (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mcsp_pkg::chan_ctrl_t         ctrl,
	input  logic [mcsp_pkg::DUTY_W-1:0]  duty_in,
	input  logic [mcsp_pkg::COUNT_W-1:0] count_next,
	input  logic [mcsp_pkg::COUNT_W-1:0] period,
	output logic [mcsp_pkg::DUTY_W-1:0]  duty,
	output logic                         on
);

	localparam int POS_W = mcsp_pkg::COUNT_W + 10;
	localparam int LIM_W = mcsp_pkg::COUNT_W + mcsp_pkg::DUTY_W;

	logic [mcsp_pkg::DUTY_W-1:0] duty_q;
	logic                        on_q;
	logic [POS_W-1:0]            pos;
	logic [LIM_W-1:0]            lim;
	logic                        on_tick;

	// window position against duty share of the period
	assign pos = {count_next, 10'd0};
	assign lim = LIM_W'(duty_q) * LIM_W'(period);
	assign on_tick = (duty_q >= mcsp_pkg::DUTY_SAT)
		|| ((duty_q != '0) && (LIM_W'(pos) < lim));

	// next duty
	always_comb begin
		duty = duty_q;
		if (ctrl.clear) begin
			duty = '0;
		end else if (ctrl.load) begin
			duty = duty_in;
		end
	end

	// next on flag
	always_comb begin
		on = on_q;
		if (ctrl.clear || ctrl.tick_off) begin
			on = 1'b0;
		end else if (ctrl.tick_run) begin
			on = on_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
			on_q   <= 1'b0;
		end else begin
			duty_q <= duty;
			on_q   <= on;
		end
	end

endmodule

>>> sv/multi_channel_slow_pwm_unit.sv
// multi_channel_slow_pwm_unit: top level with input stage, window counter,
// channel array and result register; depends on mcsp_pkg and mcsp_chan
//
//   port group  dir  handshake            payload
//   req         in   req_valid/req_stall  req_data  (mcsp_pkg::req_item_t)
//   res         out  res_valid/res_stall  res_data  (mcsp_pkg::res_item_t)
//   cfg         in   cfg_we               cfg_index, cfg_data
//
// one request a cycle while no result stall holds the input; each request gives one
// result, passing through the input register and then the result register, with the
// window counter step and one duty times period compare per channel between them.
// reset clears all duties and on flags, zeroes the window and enables output.
// a stalled result holds; the input register still takes one more request.
module multi_channel_slow_pwm_unit #(
	parameter int CHANNELS = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  mcsp_pkg::req_item_t          req_data,
	output logic                         res_valid,
	input  logic                         res_stall,
	output mcsp_pkg::res_item_t          res_data,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [mcsp_pkg::COUNT_W-1:0] cfg_data
);

	localparam int CW = mcsp_pkg::COUNT_W;
	localparam int DW = mcsp_pkg::DUTY_W;
	localparam int PW = mcsp_pkg::PINS_W;

	logic                 valid_s1;
	mcsp_pkg::req_item_t  item_s1;
	logic                 advance;
	logic                 res_valid_q;
	mcsp_pkg::res_item_t  res_q;

	logic [CW-1:0]        period_q;
	logic                 active_high_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_next;
	logic                 enabled_q;
	logic                 enabled_next;
	logic [CW:0]          count_inc;

	logic [DW-1:0]        duty_clamped;
	logic                 ch_valid;
	logic [DW-1:0]        duty_nx [CHANNELS];
	logic [CHANNELS-1:0]  on_nx;
	logic [PW-1:0]        on_bits;
	logic [DW-1:0]        readback;
	mcsp_pkg::res_item_t  res_d;

	// handshake: input stage moves on when the result register is free
	assign advance   = valid_s1 && !(res_valid_q && res_stall);
	assign req_stall = valid_s1 && !advance;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req_data;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= mcsp_pkg::PERIOD_RESET;
			active_high_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcsp_pkg::CFG_PERIOD:      period_q      <= cfg_data;
				mcsp_pkg::CFG_ACTIVE_HIGH: active_high_q <= cfg_data[0];
				default:                   period_q      <= period_q;
			endcase
		end
	end

	// window counter and enable flag
	assign count_inc = {1'b0, count_q} + (CW+1)'(1);

	always_comb begin
		count_next   = count_q;
		enabled_next = enabled_q;
		unique case (item_s1.req_type)
			mcsp_pkg::REQ_TICK: begin
				if (enabled_q) begin
					count_next = (count_inc >= {1'b0, period_q}) ? '0 : count_inc[CW-1:0];
				end
			end
			mcsp_pkg::REQ_SET: begin
				count_next = count_q;
			end
			mcsp_pkg::REQ_OFF: begin
				enabled_next = 1'b0;
			end
			mcsp_pkg::REQ_ENABLE: begin
				enabled_next = 1'b1;
				count_next   = '0;
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			enabled_q <= 1'b1;
		end else if (advance) begin
			count_q   <= count_next;
			enabled_q <= enabled_next;
		end
	end

	// duty clamp and channel check
	assign duty_clamped = (item_s1.duty_value > mcsp_pkg::DUTY_FULL)
		? mcsp_pkg::DUTY_FULL : item_s1.duty_value;
	assign ch_valid = int'(item_s1.channel) < CHANNELS;

	// channel array
	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		mcsp_pkg::chan_ctrl_t ctrl;

		assign ctrl.load     = advance && (item_s1.req_type == mcsp_pkg::REQ_SET)
			&& (int'(item_s1.channel) == i);
		assign ctrl.clear    = advance && (item_s1.req_type == mcsp_pkg::REQ_OFF);
		assign ctrl.tick_run = advance && (item_s1.req_type == mcsp_pkg::REQ_TICK) && enabled_q;
		assign ctrl.tick_off = advance && (item_s1.req_type == mcsp_pkg::REQ_TICK) && !enabled_q;

		mcsp_chan u_chan (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.duty_in    (duty_clamped),
			.count_next (count_next),
			.period     (period_q),
			.duty       (duty_nx[i]),
			.on         (on_nx[i])
		);
	end

	// on bits for the pin field, channels beyond its width dropped
	for (genvar b = 0; b < PW; b++) begin : g_bits
		if (b < CHANNELS) begin : g_on
			assign on_bits[b] = on_nx[b];
		end else begin : g_off
			assign on_bits[b] = 1'b0;
		end
	end

	// readback of the addressed channel after the update
	always_comb begin
		readback = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (int'(item_s1.channel) == i) begin
				readback = duty_nx[i];
			end
		end
	end

	// result assembly
	always_comb begin
		res_d.pin_levels     = active_high_q ? on_bits : ~on_bits;
		res_d.channels_on    = on_bits;
		res_d.output_enabled = enabled_next;
		res_d.duty_readback  = readback;
		res_d.status         = (item_s1.req_type == mcsp_pkg::REQ_SET) && !ch_valid;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	// a taken result with nothing behind it leaves the output empty
	a_res_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !advance) |=> !res_valid)
		else $error("result register kept a transferred result");

	// enable restarts the window and shows output enabled
	a_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.req_type == mcsp_pkg::REQ_ENABLE))
		|=> (count_q == '0) && res_data.output_enabled)
		else $error("enable did not restart the window");

	// disabled output never shows a channel on
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.output_enabled) |-> (res_data.channels_on == '0))
		else $error("channel on while output disabled");

	// an invalid channel error reads back no duty
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.status) |-> (res_data.duty_readback == '0))
		else $error("error status with nonzero readback");

	// the input stage only stalls while the result register is blocked
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (res_valid && res_stall))
		else $error("input stalled with free result register");
`endif

endmodule

>>> test/tb_top.sv
// tb_top: self-checking testbench for multi_channel_slow_pwm_unit
// depends on mcsp_pkg and the unit; holds its own cycle-free model of the pwm channels
module tb_top;

	localparam int NCH       = 3;
	localparam int HALF      = 5;
	localparam int RUN_LIMIT = 2_000_000;
	localparam int SETTLE    = 8;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         req_valid = 1'b0;
	logic                         req_stall;
	mcsp_pkg::req_item_t          req_data  = '0;
	logic                         res_valid;
	logic                         res_stall = 1'b0;
	mcsp_pkg::res_item_t          res_data;
	logic                         cfg_we    = 1'b0;
	logic                         cfg_index = mcsp_pkg::CFG_PERIOD;
	logic [mcsp_pkg::COUNT_W-1:0] cfg_data  = '0;

	multi_channel_slow_pwm_unit #(
		.CHANNELS(NCH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF clk = ~clk;

	// model state of the pwm channels
	logic [mcsp_pkg::DUTY_W-1:0]  duty_mem [NCH];
	logic [NCH-1:0]               on_mem;
	logic [mcsp_pkg::COUNT_W-1:0] win_count;
	logic [mcsp_pkg::COUNT_W-1:0] period_reg;
	logic                         en_flag;
	logic                         act_high;

	mcsp_pkg::res_item_t pending_results [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count    = 0;
	int req_count     = 0;
	int res_count     = 0;
	int cfg_count     = 0;

	task automatic pwm_model_reset();
		for (int i = 0; i < NCH; i++)
			duty_mem[i] = '0;
		on_mem     = '0;
		win_count  = '0;
		period_reg = mcsp_pkg::PERIOD_RESET;
		en_flag    = 1'b1;
		act_high   = 1'b1;
	endtask

	// apply one request to the model and return the result it produces
	function automatic mcsp_pkg::res_item_t pwm_step(input mcsp_pkg::req_item_t rq);
		mcsp_pkg::res_item_t          rs;
		logic [mcsp_pkg::DUTY_W-1:0]  duty;
		logic [mcsp_pkg::COUNT_W:0]   next;
		logic [31:0]                  pos;
		logic [31:0]                  lim;
		logic                         ch_ok;
		logic                         stat;
		duty  = (rq.duty_value > mcsp_pkg::DUTY_FULL) ? mcsp_pkg::DUTY_FULL : rq.duty_value;
		ch_ok = (rq.channel < NCH);
		stat  = 1'b0;
		case (rq.req_type)
			mcsp_pkg::REQ_TICK: begin
				if (!en_flag) begin
					on_mem = '0;
				end else begin
					next = {1'b0, win_count} + 1'b1;
					if (next >= {1'b0, period_reg})
						next = '0;
					win_count = next[mcsp_pkg::COUNT_W-1:0];
					for (int i = 0; i < NCH; i++) begin
						pos = 32'(win_count) * 32'(mcsp_pkg::DUTY_FULL);
						lim = 32'(duty_mem[i]) * 32'(period_reg);
						on_mem[i] = (duty_mem[i] >= mcsp_pkg::DUTY_SAT) ||
							(duty_mem[i] != '0 && pos < lim);
					end
				end
			end
			mcsp_pkg::REQ_SET: begin
				if (ch_ok)
					duty_mem[rq.channel] = duty;
				else
					stat = 1'b1;
			end
			mcsp_pkg::REQ_OFF: begin
				en_flag = 1'b0;
				on_mem  = '0;
				for (int i = 0; i < NCH; i++)
					duty_mem[i] = '0;
			end
			default: begin
				en_flag   = 1'b1;
				win_count = '0;
			end
		endcase
		rs.channels_on    = on_mem;
		rs.pin_levels     = act_high ? on_mem : ~on_mem;
		rs.output_enabled = en_flag;
		rs.duty_readback  = '0;
		if (ch_ok)
			rs.duty_readback = duty_mem[rq.channel];
		rs.status         = stat;
		return rs;
	endfunction

	// track register writes and accepted request transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == mcsp_pkg::CFG_PERIOD)
					period_reg = cfg_data;
				else
					act_high = cfg_data[0];
				cfg_count++;
			end
			if (req_valid && !req_stall) begin
				pending_results.push_back(pwm_step(req_data));
				req_count++;
			end
		end
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		mcsp_pkg::res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			res_count++;
			if (pending_results.size() == 0) begin
				$error("unexpected result %p", res_data);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_data.pin_levels !== want.pin_levels) begin
					$error("pin_levels exp %0h act %0h", want.pin_levels,
						res_data.pin_levels);
					fail_count++;
				end
				if (res_data.channels_on !== want.channels_on) begin
					$error("channels_on exp %0h act %0h", want.channels_on,
						res_data.channels_on);
					fail_count++;
				end
				if (res_data.output_enabled !== want.output_enabled) begin
					$error("output_enabled exp %0d act %0d", want.output_enabled,
						res_data.output_enabled);
					fail_count++;
				end
				if (res_data.duty_readback !== want.duty_readback) begin
					$error("duty_readback exp %0d act %0d", want.duty_readback,
						res_data.duty_readback);
					fail_count++;
				end
				if (res_data.status !== want.status) begin
					$error("status exp %0d act %0d", want.status, res_data.status);
					fail_count++;
				end
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		res_stall <= ($urandom_range(99) < recv_idle_pct);

	// send one request; entered and left at a falling edge, valid stays high
	task automatic send_req(input mcsp_pkg::req_kind_t kind, input logic [1:0] ch,
			input logic [mcsp_pkg::DUTY_W-1:0] duty);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid           <= 1'b1;
		req_data.req_type   <= kind;
		req_data.channel    <= ch;
		req_data.duty_value <= duty;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop sending and wait until every predicted result has arrived
	task automatic drain();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [mcsp_pkg::COUNT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_reset_defaults();
		for (int c = 0; c < 4; c++)
			send_req(mcsp_pkg::REQ_TICK, 2'(c), '0);
		drain();
	endtask

	task automatic test_duty_limits();
		send_req(mcsp_pkg::REQ_SET, 2'd0, mcsp_pkg::DUTY_SAT);
		send_req(mcsp_pkg::REQ_SET, 2'd1, 11'h7FF);       // clamps to full
		send_req(mcsp_pkg::REQ_SET, 2'd2, 11'd1);
		send_req(mcsp_pkg::REQ_SET, 2'd3, 11'd5);         // invalid channel
		send_req(mcsp_pkg::REQ_TICK, 2'd1, '0);
		send_req(mcsp_pkg::REQ_TICK, 2'd2, '0);
		send_req(mcsp_pkg::REQ_SET, 2'd2, 11'd1022);
		send_req(mcsp_pkg::REQ_SET, 2'd0, '0);
		send_req(mcsp_pkg::REQ_TICK, 2'd0, 11'h7FF);
		drain();
	endtask

	task automatic test_off_and_enable();
		send_req(mcsp_pkg::REQ_OFF, 2'd1, '0);
		send_req(mcsp_pkg::REQ_TICK, 2'd3, '0);           // disabled tick
		send_req(mcsp_pkg::REQ_SET, 2'd1, 11'd600);       // stored while disabled
		send_req(mcsp_pkg::REQ_TICK, 2'd1, '0);
		send_req(mcsp_pkg::REQ_ENABLE, 2'd1, '0);
		send_req(mcsp_pkg::REQ_TICK, 2'd1, '0);
		send_req(mcsp_pkg::REQ_ENABLE, 2'd3, mcsp_pkg::DUTY_FULL);
		drain();
	endtask

	task automatic test_config_extremes();
		cfg_write(mcsp_pkg::CFG_ACTIVE_HIGH, 16'd0);
		cfg_write(mcsp_pkg::CFG_PERIOD, 16'd0);
		send_req(mcsp_pkg::REQ_SET, 2'd2, mcsp_pkg::DUTY_FULL);
		send_req(mcsp_pkg::REQ_TICK, 2'd0, '0);
		drain();
		cfg_write(mcsp_pkg::CFG_PERIOD, 16'd1);
		send_req(mcsp_pkg::REQ_TICK, 2'd1, '0);
		drain();
		cfg_write(mcsp_pkg::CFG_PERIOD, 16'hFFFF);
		cfg_write(mcsp_pkg::CFG_ACTIVE_HIGH, 16'hFFFF);
		send_req(mcsp_pkg::REQ_TICK, 2'd2, '0);
		send_req(mcsp_pkg::REQ_TICK, 2'd2, '0);
		drain();
	endtask

	function automatic logic [mcsp_pkg::COUNT_W-1:0] rand_period();
		case ($urandom_range(15))
			0:       return '0;
			1:       return 16'd1;
			2:       return 16'hFFFF;
			3:       return mcsp_pkg::COUNT_W'($urandom_range(65535));
			default: return mcsp_pkg::COUNT_W'($urandom_range(30, 2));
		endcase
	endfunction

	function automatic logic [mcsp_pkg::DUTY_W-1:0] rand_duty();
		case ($urandom_range(9))
			0:       return '0;
			1:       return mcsp_pkg::DUTY_SAT;
			2:       return mcsp_pkg::DUTY_FULL;
			3:       return mcsp_pkg::DUTY_W'($urandom_range(2047, 1025));
			4:       return mcsp_pkg::DUTY_W'($urandom_range(8, 1));
			default: return mcsp_pkg::DUTY_W'($urandom_range(1024));
		endcase
	endfunction

	// mostly ticks against stored duties, with rare off and re-enable
	task automatic test_random(input int s_pct, input int r_pct, input int count);
		int                  pick;
		mcsp_pkg::req_kind_t kind;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 150 == 0) begin
				drain();
				cfg_write(mcsp_pkg::CFG_PERIOD, rand_period());
				cfg_write(mcsp_pkg::CFG_ACTIVE_HIGH,
					mcsp_pkg::COUNT_W'($urandom_range(1)));
			end
			pick = $urandom_range(99);
			if (pick < 62)
				kind = mcsp_pkg::REQ_TICK;
			else if (pick < 89)
				kind = mcsp_pkg::REQ_SET;
			else if (pick < 92)
				kind = mcsp_pkg::REQ_OFF;
			else
				kind = mcsp_pkg::REQ_ENABLE;
			send_req(kind, 2'($urandom_range(3)), rand_duty());
		end
		drain();
	endtask

	initial begin
		pwm_model_reset();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_duty_limits();
		test_off_and_enable();
		test_config_extremes();
		test_random(9, 58, 600);
		test_random(58, 9, 600);
		test_random(0, 0, 600);
		recv_idle_pct = 0;
		repeat (SETTLE) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d predicted results never arrived", pending_results.size());
			fail_count++;
		end
		$display("run covered %0d requests and %0d results, %0d register writes,",
			req_count, res_count, cfg_count);
		$display("three sender/receiver pressure phases, %0d mismatches", fail_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#(RUN_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

endmodule
